// File: sv/thavg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the digit table of the averaging thermometer
package thavg_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 12;
    localparam int SUM_W     = 16;
    localparam int LIMIT_W   = 12;
    localparam int DUTY_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int REM_W     = 7;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int TENS_STEP  = 100;
    localparam int MAX_DIGIT  = 9;

    localparam logic [AVG_W-1:0]     OVER_LIMIT = 12'd999;
    localparam logic [3*DIGIT_W-1:0] SAT_DIGITS = 12'h999;

    localparam logic [LIMIT_W-1:0] NORMAL_LIMIT_RST = 12'd370;
    localparam logic [LIMIT_W-1:0] ALARM_LIMIT_RST  = 12'd375;
    localparam logic [DUTY_W-1:0]  DUTY_NORMAL_RST  = 8'd5;
    localparam logic [DUTY_W-1:0]  DUTY_WARNING_RST = 8'd19;
    localparam logic [DUTY_W-1:0]  DUTY_ALARM_RST   = 8'd32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NORMAL_LIMIT = 3'd0,
        REG_ALARM_LIMIT  = 3'd1,
        REG_DUTY_NORMAL  = 3'd2,
        REG_DUTY_WARNING = 3'd3,
        REG_DUTY_ALARM   = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ZONE_NORMAL  = 2'd0,
        ZONE_WARNING = 2'd1,
        ZONE_ALARM   = 2'd2
    } zone_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mv;
        logic                capture;
    } in_word_t;

    typedef struct packed {
        logic [AVG_W-1:0]   average_mv;
        logic [DIGIT_W-1:0] shown_tens;
        logic [DIGIT_W-1:0] shown_units;
        logic [DIGIT_W-1:0] shown_tenths;
        logic [1:0]         zone;
        logic [DUTY_W-1:0]  servo_duty;
        logic               over_range;
    } out_word_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] normal_limit;
        logic [LIMIT_W-1:0] alarm_limit;
        logic [DUTY_W-1:0]  duty_normal;
        logic [DUTY_W-1:0]  duty_warning;
        logic [DUTY_W-1:0]  duty_alarm;
    } cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg;
        logic             capture;
    } avg_word_t;

    // remainder below one hundred to units and tenths digits
    typedef logic [(1 << REM_W)-1:0][2*DIGIT_W-1:0] bcd_table_t;

    function automatic bcd_table_t build_bcd_table();
        bcd_table_t tab;
        for (int i = 0; i < (1 << REM_W); i++) begin
            tab[i] = {DIGIT_W'((i / 10) % 10), DIGIT_W'(i % 10)};
        end
        return tab;
    endfunction

    localparam bcd_table_t BCD_TABLE = build_bcd_table();

endpackage

// File: sv/thavg_cfg.sv
`timescale 1ns / 1ps
// apb register file for zone limits and servo duties
module thavg_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thavg_pkg::ADDR_W-1:0]  paddr,
    input  logic [thavg_pkg::DATA_W-1:0]  pwdata,
    output logic [thavg_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output thavg_pkg::cfg_t               cfg
);

    logic [thavg_pkg::LIMIT_W-1:0] normal_limit_reg;
    logic [thavg_pkg::LIMIT_W-1:0] alarm_limit_reg;
    logic [thavg_pkg::DUTY_W-1:0]  duty_normal_reg;
    logic [thavg_pkg::DUTY_W-1:0]  duty_warning_reg;
    logic [thavg_pkg::DUTY_W-1:0]  duty_alarm_reg;
    logic                          wr_en;
    thavg_pkg::reg_index_t         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = thavg_pkg::reg_index_t'(paddr[thavg_pkg::ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_limit_reg <= thavg_pkg::NORMAL_LIMIT_RST;
            alarm_limit_reg  <= thavg_pkg::ALARM_LIMIT_RST;
            duty_normal_reg  <= thavg_pkg::DUTY_NORMAL_RST;
            duty_warning_reg <= thavg_pkg::DUTY_WARNING_RST;
            duty_alarm_reg   <= thavg_pkg::DUTY_ALARM_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                thavg_pkg::REG_NORMAL_LIMIT: begin
                    normal_limit_reg <= pwdata[thavg_pkg::LIMIT_W-1:0];
                end
                thavg_pkg::REG_ALARM_LIMIT: begin
                    alarm_limit_reg <= pwdata[thavg_pkg::LIMIT_W-1:0];
                end
                thavg_pkg::REG_DUTY_NORMAL: begin
                    duty_normal_reg <= pwdata[thavg_pkg::DUTY_W-1:0];
                end
                thavg_pkg::REG_DUTY_WARNING: begin
                    duty_warning_reg <= pwdata[thavg_pkg::DUTY_W-1:0];
                end
                thavg_pkg::REG_DUTY_ALARM: begin
                    duty_alarm_reg <= pwdata[thavg_pkg::DUTY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            thavg_pkg::REG_NORMAL_LIMIT: prdata = thavg_pkg::DATA_W'(normal_limit_reg);
            thavg_pkg::REG_ALARM_LIMIT:  prdata = thavg_pkg::DATA_W'(alarm_limit_reg);
            thavg_pkg::REG_DUTY_NORMAL:  prdata = thavg_pkg::DATA_W'(duty_normal_reg);
            thavg_pkg::REG_DUTY_WARNING: prdata = thavg_pkg::DATA_W'(duty_warning_reg);
            thavg_pkg::REG_DUTY_ALARM:   prdata = thavg_pkg::DATA_W'(duty_alarm_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.normal_limit = normal_limit_reg;
    assign cfg.alarm_limit  = alarm_limit_reg;
    assign cfg.duty_normal  = duty_normal_reg;
    assign cfg.duty_warning = duty_warning_reg;
    assign cfg.duty_alarm   = duty_alarm_reg;

endmodule

// File: sv/thavg_window.sv
`timescale 1ns / 1ps
// sample ring, running sum and divide by window length
module thavg_window #(
    parameter int WINDOW = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  thavg_pkg::in_word_t  s_data,
    output logic                 o_valid,
    input  logic                 o_ready,
    output thavg_pkg::avg_word_t o_data
);

    localparam int POS_W   = $clog2(WINDOW);
    localparam int SHIFT   = 17;
    localparam int RECIP_W = SHIFT;
    localparam int PROD_W  = thavg_pkg::SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((1 << SHIFT) / WINDOW);
    localparam logic [thavg_pkg::SUM_W-1:0] WINDOW_K = thavg_pkg::SUM_W'(WINDOW);
    localparam logic [thavg_pkg::SUM_W-1:0] MAX_SUM =
        thavg_pkg::SUM_W'(WINDOW * thavg_pkg::SAMPLE_MAX);

    logic [thavg_pkg::SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [POS_W-1:0]               pos_reg;
    logic [POS_W-1:0]               pos_next;
    logic [thavg_pkg::SUM_W-1:0]    sum_reg;
    logic [thavg_pkg::SUM_W-1:0]    sum_next;

    logic                           a_valid_reg;
    logic [thavg_pkg::SUM_W-1:0]    a_sum_reg;
    logic                           a_capture_reg;
    logic                           b_valid_reg;
    logic [thavg_pkg::SUM_W-1:0]    b_sum_reg;
    logic [thavg_pkg::AVG_W-1:0]    b_quot_reg;
    logic [thavg_pkg::AVG_W-1:0]    b_quot_next;
    logic                           b_capture_reg;
    logic                           c_valid_reg;
    thavg_pkg::avg_word_t           c_data_reg;
    thavg_pkg::avg_word_t           c_data_next;

    logic                           a_ready;
    logic                           b_ready;
    logic                           c_ready;
    logic                           accept;
    logic [PROD_W-1:0]              prod;
    logic [thavg_pkg::SUM_W-1:0]    quot_times_w;
    logic [thavg_pkg::SUM_W-1:0]    rem;

    assign c_ready = !c_valid_reg || o_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign accept  = s_valid && a_ready;

    assign sum_next = sum_reg - thavg_pkg::SUM_W'(ring_reg[pos_reg])
                    + thavg_pkg::SUM_W'(s_data.sample_mv);
    assign pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);

    // reciprocal multiply, low by at most one
    assign prod        = PROD_W'(a_sum_reg) * PROD_W'(RECIP_K);
    assign b_quot_next = prod[SHIFT +: thavg_pkg::AVG_W];

    // one-step correction of the quotient
    assign quot_times_w = thavg_pkg::SUM_W'(b_quot_reg) * WINDOW_K;
    assign rem          = b_sum_reg - quot_times_w;
    always_comb begin
        c_data_next.capture = b_capture_reg;
        if (rem >= WINDOW_K) begin
            c_data_next.avg = b_quot_reg + thavg_pkg::AVG_W'(1);
        end else begin
            c_data_next.avg = b_quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            pos_reg     <= '0;
            sum_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ring_reg[pos_reg] <= s_data.sample_mv;
                pos_reg           <= pos_next;
                sum_reg           <= sum_next;
            end
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_sum_reg     <= sum_next;
            a_capture_reg <= s_data.capture;
        end
        if (a_valid_reg && b_ready) begin
            b_sum_reg     <= a_sum_reg;
            b_quot_reg    <= b_quot_next;
            b_capture_reg <= a_capture_reg;
        end
        if (b_valid_reg && c_ready) begin
            c_data_reg <= c_data_next;
        end
    end

    assign o_valid = c_valid_reg;
    assign o_data  = c_data_reg;

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= MAX_SUM)
        else $error("running sum above full-scale window total");

endmodule

// File: sv/thavg_digits.sv
`timescale 1ns / 1ps
// digit split, zone compare, capture latch and result register
module thavg_digits (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  thavg_pkg::avg_word_t i_data,
    input  thavg_pkg::cfg_t      cfg,
    output logic                 m_valid,
    input  logic                 m_ready,
    output thavg_pkg::out_word_t m_data
);

    localparam int DW = thavg_pkg::DIGIT_W;

    logic                           d_valid_reg;
    logic [thavg_pkg::AVG_W-1:0]    d_avg_reg;
    logic [DW-1:0]                  d_tens_reg;
    logic [thavg_pkg::REM_W-1:0]    d_rem_reg;
    logic                           d_over_reg;
    thavg_pkg::zone_t               d_zone_reg;
    logic                           d_capture_reg;

    logic [DW-1:0]                  tens;
    logic [thavg_pkg::REM_W-1:0]    rem;
    logic                           over;
    thavg_pkg::zone_t               zone;

    logic [3*DW-1:0]                latched_digits_reg;
    logic [3*DW-1:0]                latched_digits_next;
    thavg_pkg::zone_t               latched_zone_reg;
    thavg_pkg::zone_t               latched_zone_next;
    logic                           latched_over_reg;
    logic                           latched_over_next;
    logic [thavg_pkg::DUTY_W-1:0]   duty;

    logic                           m_valid_reg;
    thavg_pkg::out_word_t           m_data_reg;
    logic                           e_ready;
    logic                           d_ready;
    logic                           load_e;

    assign e_ready = !m_valid_reg || m_ready;
    assign d_ready = !d_valid_reg || e_ready;
    assign i_ready = d_ready;
    assign load_e  = d_valid_reg && e_ready;

    // hundreds step by compare against fixed thresholds
    always_comb begin
        tens = '0;
        rem  = thavg_pkg::REM_W'(i_data.avg);
        for (int k = 1; k <= thavg_pkg::MAX_DIGIT; k++) begin
            if (i_data.avg >= thavg_pkg::AVG_W'(thavg_pkg::TENS_STEP * k)) begin
                tens = DW'(k);
                rem  = thavg_pkg::REM_W'(i_data.avg
                       - thavg_pkg::AVG_W'(thavg_pkg::TENS_STEP * k));
            end
        end
    end

    assign over = i_data.avg > thavg_pkg::OVER_LIMIT;

    // alarm wins over normal when limits overlap
    always_comb begin
        if (i_data.avg >= cfg.alarm_limit) begin
            zone = thavg_pkg::ZONE_ALARM;
        end else if (i_data.avg <= cfg.normal_limit) begin
            zone = thavg_pkg::ZONE_NORMAL;
        end else begin
            zone = thavg_pkg::ZONE_WARNING;
        end
    end

    always_comb begin
        latched_digits_next = latched_digits_reg;
        latched_zone_next   = latched_zone_reg;
        latched_over_next   = latched_over_reg;
        if (load_e && d_capture_reg) begin
            latched_zone_next = d_zone_reg;
            latched_over_next = d_over_reg;
            if (d_over_reg) begin
                latched_digits_next = thavg_pkg::SAT_DIGITS;
            end else begin
                latched_digits_next = {d_tens_reg, thavg_pkg::BCD_TABLE[d_rem_reg]};
            end
        end
    end

    always_comb begin
        case (latched_zone_next)
            thavg_pkg::ZONE_NORMAL:  duty = cfg.duty_normal;
            thavg_pkg::ZONE_WARNING: duty = cfg.duty_warning;
            default:                 duty = cfg.duty_alarm;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
            latched_digits_reg <= '0;
            latched_zone_reg   <= thavg_pkg::ZONE_NORMAL;
            latched_over_reg   <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= i_valid;
            end
            if (e_ready) begin
                m_valid_reg <= d_valid_reg;
            end
            latched_digits_reg <= latched_digits_next;
            latched_zone_reg   <= latched_zone_next;
            latched_over_reg   <= latched_over_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_valid && d_ready) begin
            d_avg_reg     <= i_data.avg;
            d_tens_reg    <= tens;
            d_rem_reg     <= rem;
            d_over_reg    <= over;
            d_zone_reg    <= zone;
            d_capture_reg <= i_data.capture;
        end
        if (load_e) begin
            m_data_reg.average_mv   <= d_avg_reg;
            m_data_reg.shown_tens   <= latched_digits_next[3*DW-1:2*DW];
            m_data_reg.shown_units  <= latched_digits_next[2*DW-1:DW];
            m_data_reg.shown_tenths <= latched_digits_next[DW-1:0];
            m_data_reg.zone         <= latched_zone_next;
            m_data_reg.servo_duty   <= duty;
            m_data_reg.over_range   <= latched_over_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_over_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.over_range |->
            m_data_reg.shown_tens == DW'(thavg_pkg::MAX_DIGIT) &&
            m_data_reg.shown_units == DW'(thavg_pkg::MAX_DIGIT) &&
            m_data_reg.shown_tenths == DW'(thavg_pkg::MAX_DIGIT))
        else $error("over range without saturated digits");

    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |->
            m_data_reg.shown_tens <= DW'(thavg_pkg::MAX_DIGIT) &&
            m_data_reg.shown_units <= DW'(thavg_pkg::MAX_DIGIT) &&
            m_data_reg.shown_tenths <= DW'(thavg_pkg::MAX_DIGIT))
        else $error("shown digit not decimal");

    a_capture_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        load_e && d_capture_reg |=> m_data_reg.zone == 2'($past(d_zone_reg)))
        else $error("captured word does not show its own zone");

    a_latch_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(load_e && d_capture_reg) |=>
            $stable(latched_digits_reg) && $stable(latched_zone_reg) &&
            $stable(latched_over_reg))
        else $error("latch changed without a capture");

endmodule

// File: sv/thermometer_average_digits_zone.sv
`timescale 1ns / 1ps
// top level of the moving-average thermometer with digit split and zone latch
//
// s_ channel: one sensor word per handshake, millivolts plus a capture bit.
// m_ channel: exactly one result word per input word, in order: the window
//   average and the latched digits, zone, over-range flag and servo duty.
// apb port: zone limits at 0x00/0x04, duties at 0x08/0x0c/0x10; pready
//   is tied high, writes belong in idle periods.
// pipeline: a result passes five registers after its input is taken
//   (sum update, reciprocal multiply, quotient correction, digit split,
//   result register); with m_ready high one word per cycle is sustained.
// the ring and running sum update at the input handshake; the capture
//   latch updates as the word enters the result register.
// a stalled m_ side holds the result register; stages behind it keep
//   filling until the five-deep pipeline is full, then s_ready drops.
// reset clears the ring, sum, latch and pipeline, and loads default
//   limits and duties.
module thermometer_average_digits_zone #(
    parameter int WINDOW = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  thavg_pkg::in_word_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output thavg_pkg::out_word_t          m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thavg_pkg::ADDR_W-1:0]  paddr,
    input  logic [thavg_pkg::DATA_W-1:0]  pwdata,
    output logic [thavg_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    thavg_pkg::cfg_t      cfg;
    thavg_pkg::avg_word_t avg_data;
    logic                 avg_valid;
    logic                 avg_ready;

    thavg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thavg_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .o_valid (avg_valid),
        .o_ready (avg_ready),
        .o_data  (avg_data)
    );

    thavg_digits u_digits (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (avg_valid),
        .i_ready (avg_ready),
        .i_data  (avg_data),
        .cfg     (cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/sv/tb_thermometer_average_digits_zone.sv
`timescale 1ns / 1ps
// testbench for the moving-average thermometer: streams samples, predicts every result word
module tb_thermometer_average_digits_zone;

    localparam int WIN          = 10;
    localparam int REG_COUNT    = 5;
    localparam int LIMIT_CYCLES = 400000;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    thavg_pkg::in_word_t                 s_data;
    logic                                m_valid;
    logic                                m_ready;
    thavg_pkg::out_word_t                m_data;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [thavg_pkg::ADDR_W-1:0]        paddr;
    logic [thavg_pkg::DATA_W-1:0]        pwdata;
    logic [thavg_pkg::DATA_W-1:0]        prdata;
    logic                                pready;

    // model of the filter
    logic [thavg_pkg::SAMPLE_W-1:0]      ring_mv [WIN];
    int                                  ring_pos;
    logic [thavg_pkg::SUM_W-1:0]         sum_mv;
    logic [3*thavg_pkg::DIGIT_W-1:0]     held_bcd;
    thavg_pkg::zone_t                    held_zone;
    logic                                held_over;
    thavg_pkg::cfg_t                     model_cfg;

    thavg_pkg::out_word_t                pending_words[$];
    int                                  mismatches;
    int                                  cycles;
    int                                  hold_len;
    bit                                  src_idle_on;
    bit                                  sink_idle_on;

    thermometer_average_digits_zone #(
        .WINDOW(WIN)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void clear_model();
        for (int i = 0; i < WIN; i++) ring_mv[i] = '0;
        ring_pos  = 0;
        sum_mv    = '0;
        held_bcd  = '0;
        held_zone = thavg_pkg::ZONE_NORMAL;
        held_over = 1'b0;
        model_cfg.normal_limit = thavg_pkg::NORMAL_LIMIT_RST;
        model_cfg.alarm_limit  = thavg_pkg::ALARM_LIMIT_RST;
        model_cfg.duty_normal  = thavg_pkg::DUTY_NORMAL_RST;
        model_cfg.duty_warning = thavg_pkg::DUTY_WARNING_RST;
        model_cfg.duty_alarm   = thavg_pkg::DUTY_ALARM_RST;
    endfunction

    function automatic thavg_pkg::out_word_t track_average(thavg_pkg::in_word_t w);
        thavg_pkg::out_word_t o;
        int                   avg;
        logic [3:0]           tens, units, tenths;
        sum_mv = sum_mv - thavg_pkg::SUM_W'(ring_mv[ring_pos])
               + thavg_pkg::SUM_W'(w.sample_mv);
        ring_mv[ring_pos] = w.sample_mv;
        ring_pos = (ring_pos + 1) % WIN;
        avg = int'(sum_mv) / WIN;
        if (w.capture) begin
            if (avg > 999) begin
                held_bcd  = thavg_pkg::SAT_DIGITS;
                held_over = 1'b1;
            end else begin
                tens      = 4'(avg / 100);
                units     = 4'((avg / 10) % 10);
                tenths    = 4'(avg % 10);
                held_bcd  = {tens, units, tenths};
                held_over = 1'b0;
            end
            if (avg >= int'(model_cfg.alarm_limit)) held_zone = thavg_pkg::ZONE_ALARM;
            else if (avg <= int'(model_cfg.normal_limit)) held_zone = thavg_pkg::ZONE_NORMAL;
            else held_zone = thavg_pkg::ZONE_WARNING;
        end
        o.average_mv   = thavg_pkg::AVG_W'(avg);
        o.shown_tens   = held_bcd[11:8];
        o.shown_units  = held_bcd[7:4];
        o.shown_tenths = held_bcd[3:0];
        o.zone         = held_zone;
        o.over_range   = held_over;
        case (held_zone)
            thavg_pkg::ZONE_NORMAL:  o.servo_duty = model_cfg.duty_normal;
            thavg_pkg::ZONE_WARNING: o.servo_duty = model_cfg.duty_warning;
            default:                 o.servo_duty = model_cfg.duty_alarm;
        endcase
        return o;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        thavg_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t unexpected word: expected none actual %h", $time, m_data);
            end else begin
                want = pending_words.pop_front();
                check_field("average_mv", 16'(want.average_mv), 16'(m_data.average_mv));
                check_field("shown_tens", 16'(want.shown_tens), 16'(m_data.shown_tens));
                check_field("shown_units", 16'(want.shown_units), 16'(m_data.shown_units));
                check_field("shown_tenths", 16'(want.shown_tenths),
                            16'(m_data.shown_tenths));
                check_field("zone", 16'(want.zone), 16'(m_data.zone));
                check_field("servo_duty", 16'(want.servo_duty), 16'(m_data.servo_duty));
                check_field("over_range", 16'(want.over_range), 16'(m_data.over_range));
            end
        end
    end

    // result side: random stalls and requested long hold-offs
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                m_ready = 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
                m_ready = 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic [thavg_pkg::SAMPLE_W-1:0] mv, input logic cap);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_data.sample_mv = mv;
        s_data.capture   = cap;
        do @(posedge aclk); while (!s_ready);
        pending_words.push_back(track_average(s_data));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [thavg_pkg::DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = thavg_pkg::ADDR_W'(idx * 4);
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            thavg_pkg::REG_NORMAL_LIMIT:
                model_cfg.normal_limit = val[thavg_pkg::LIMIT_W-1:0];
            thavg_pkg::REG_ALARM_LIMIT:
                model_cfg.alarm_limit  = val[thavg_pkg::LIMIT_W-1:0];
            thavg_pkg::REG_DUTY_NORMAL:
                model_cfg.duty_normal  = val[thavg_pkg::DUTY_W-1:0];
            thavg_pkg::REG_DUTY_WARNING:
                model_cfg.duty_warning = val[thavg_pkg::DUTY_W-1:0];
            thavg_pkg::REG_DUTY_ALARM:
                model_cfg.duty_alarm   = val[thavg_pkg::DUTY_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_limits(input int normal, input int alarm, input int dn, input int dw,
                               input int da);
        drain_results();
        write_reg(thavg_pkg::REG_NORMAL_LIMIT, normal);
        write_reg(thavg_pkg::REG_ALARM_LIMIT, alarm);
        write_reg(thavg_pkg::REG_DUTY_NORMAL, dn);
        write_reg(thavg_pkg::REG_DUTY_WARNING, dw);
        write_reg(thavg_pkg::REG_DUTY_ALARM, da);
    endtask

    task automatic stream_samples(input int count, input int lo, input int hi);
        int level;
        int offs;
        int mv;
        level = $urandom_range(lo, hi);
        for (int n = 0; n < count; n++) begin
            if (n % 30 == 29) level = $urandom_range(lo, hi);
            offs = $urandom_range(0, 80);
            case ($urandom_range(0, 9))
                7, 8:    mv = $urandom_range(0, 3300);
                9:       mv = $urandom_range(0, thavg_pkg::SAMPLE_MAX);
                default: mv = level + offs - 40;
            endcase
            if (mv < 0) mv = 0;
            if (mv > thavg_pkg::SAMPLE_MAX) mv = thavg_pkg::SAMPLE_MAX;
            send_word(mv[thavg_pkg::SAMPLE_W-1:0], $urandom_range(0, 2) == 0);
        end
    endtask

    // warm-up from an empty ring, field extremes and over-range
    task automatic test_warmup_extremes();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_word(12'd0, 1'b1);
        send_word(12'd4095, 1'b1);
        send_word(12'd4095, 1'b0);
        send_word(12'd3300, 1'b1);
        send_word(12'd1, 1'b1);
        send_word(12'd4094, 1'b0);
        send_word(12'd2048, 1'b1);
    endtask

    // averages land exactly on both limits and between them
    task automatic test_zone_edges();
        load_limits(100, 200, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        repeat (10) send_word(12'd100, 1'b1);
        repeat (10) send_word(12'd200, 1'b1);
    endtask

    // normal limit above alarm limit, and writes to unmapped registers
    task automatic test_overlap_limits();
        load_limits(600, 300, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        for (int k = 0; k < 3; k++) write_reg(REG_COUNT + k, '1);
        stream_samples(250, 150, 750);
    endtask

    task automatic test_config_extremes();
        load_limits(0, 0, 0, 0, 0);
        stream_samples(130, 0, 1200);
        load_limits(thavg_pkg::SAMPLE_MAX, thavg_pkg::SAMPLE_MAX, 255, 255, 255);
        stream_samples(130, 0, 1200);
        load_limits(0, thavg_pkg::SAMPLE_MAX, 255, 0, 255);
        stream_samples(130, 0, 400);
    endtask

    // long result stall fills the pipeline, then the source waits for all words
    task automatic test_backpressure();
        drain_results();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_len     = 300;
        stream_samples(40, 0, 1200);
        drain_results();
    endtask

    task automatic test_random_settings();
        int normal;
        int alarm;
        for (int p = 0; p < 5; p++) begin
            normal = $urandom_range(0, 1000);
            if ($urandom_range(0, 4) == 0) alarm = $urandom_range(0, 1000);
            else alarm = normal + $urandom_range(1, 40);
            load_limits(normal, alarm, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            stream_samples(200, (normal > 80) ? normal - 80 : 0, alarm + 80);
        end
    endtask

    task automatic test_steady_stream();
        load_limits(int'(thavg_pkg::NORMAL_LIMIT_RST), int'(thavg_pkg::ALARM_LIMIT_RST),
                    int'(thavg_pkg::DUTY_NORMAL_RST), int'(thavg_pkg::DUTY_WARNING_RST),
                    int'(thavg_pkg::DUTY_ALARM_RST));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stream_samples(250, 300, 450);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_len     = 0;
        mismatches   = 0;
        cycles       = 0;
        clear_model();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_warmup_extremes();
        test_zone_edges();
        test_overlap_limits();
        test_config_extremes();
        test_backpressure();
        test_random_settings();
        test_steady_stream();

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: thermometer_average_digits_zone.f
sv/thavg_pkg.sv
sv/thavg_cfg.sv
sv/thavg_window.sv
sv/thavg_digits.sv
sv/thermometer_average_digits_zone.sv
tb/sv/tb_thermometer_average_digits_zone.sv
